// ===== rtl/rtk_pkg.sv =====
// ----------------------------------------------------------------------------
// rtk_pkg
// Shared types, bus addresses and the host key map for the raster, timer
// and keyboard I/O block.
// ----------------------------------------------------------------------------
package rtk_pkg;

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_READ  = 2'd1,
    KIND_TICK  = 2'd2,
    KIND_KEY   = 2'd3
  } kind_e;

  localparam logic [15:0] ADDR_RASTER_CTRL = 16'hd011;
  localparam logic [15:0] ADDR_RASTER_CMP  = 16'hd012;
  localparam logic [15:0] ADDR_RASTER_MASK = 16'hd01a;
  localparam logic [15:0] ADDR_PORT_A      = 16'hdc00;
  localparam logic [15:0] ADDR_PORT_B      = 16'hdc01;
  localparam logic [15:0] ADDR_TIMER_LO    = 16'hdc04;
  localparam logic [15:0] ADDR_TIMER_HI    = 16'hdc05;
  localparam logic [15:0] ADDR_ICR         = 16'hdc0d;
  localparam logic [15:0] ADDR_TIMER_CTRL  = 16'hdc0e;

  localparam logic [7:0] KEY_UP    = 8'd38;
  localparam logic [7:0] KEY_DOWN  = 8'd40;
  localparam logic [7:0] KEY_LEFT  = 8'd37;
  localparam logic [7:0] KEY_RIGHT = 8'd39;
  localparam logic [7:0] KEY_FIRE  = 8'd17;

  localparam logic [7:0] RASTER_CTRL_RESET = 8'd27;

  typedef struct packed {
    logic       en;
    logic [7:0] code;
    logic       down;
  } key_ev_t;

  // bit 6 marks a mapped key, bits 5..0 give the matrix slot
  function automatic logic [6:0] key_map(input logic [7:0] code);
    logic [6:0] m;
    m = 7'd0;
    unique case (code)
      8'd27:  m = {1'b1, 6'd63};
      8'd32:  m = {1'b1, 6'd60};
      8'd188: m = {1'b1, 6'd47};
      8'd190: m = {1'b1, 6'd44};
      8'd13:  m = {1'b1, 6'd1};
      8'd8:   m = {1'b1, 6'd0};
      8'd51:  m = {1'b1, 6'd8};
      8'd87:  m = {1'b1, 6'd9};
      8'd65:  m = {1'b1, 6'd10};
      8'd52:  m = {1'b1, 6'd11};
      8'd90:  m = {1'b1, 6'd12};
      8'd83:  m = {1'b1, 6'd13};
      8'd69:  m = {1'b1, 6'd14};
      8'd53:  m = {1'b1, 6'd16};
      8'd82:  m = {1'b1, 6'd17};
      8'd68:  m = {1'b1, 6'd18};
      8'd54:  m = {1'b1, 6'd19};
      8'd67:  m = {1'b1, 6'd20};
      8'd70:  m = {1'b1, 6'd21};
      8'd84:  m = {1'b1, 6'd22};
      8'd88:  m = {1'b1, 6'd23};
      8'd55:  m = {1'b1, 6'd24};
      8'd89:  m = {1'b1, 6'd25};
      8'd71:  m = {1'b1, 6'd26};
      8'd56:  m = {1'b1, 6'd27};
      8'd66:  m = {1'b1, 6'd28};
      8'd72:  m = {1'b1, 6'd29};
      8'd85:  m = {1'b1, 6'd30};
      8'd86:  m = {1'b1, 6'd31};
      8'd57:  m = {1'b1, 6'd32};
      8'd73:  m = {1'b1, 6'd33};
      8'd74:  m = {1'b1, 6'd34};
      8'd48:  m = {1'b1, 6'd35};
      8'd77:  m = {1'b1, 6'd36};
      8'd75:  m = {1'b1, 6'd37};
      8'd79:  m = {1'b1, 6'd38};
      8'd78:  m = {1'b1, 6'd39};
      8'd80:  m = {1'b1, 6'd41};
      8'd76:  m = {1'b1, 6'd42};
      8'd49:  m = {1'b1, 6'd56};
      8'd50:  m = {1'b1, 6'd59};
      8'd81:  m = {1'b1, 6'd62};
      default: m = 7'd0;
    endcase
    return m;
  endfunction

endpackage

// ===== rtl/rtk_keyboard.sv =====
// ----------------------------------------------------------------------------
// rtk_keyboard
// Key matrix and joystick bits, updated by host key events, with the row
// read for the lowest selected column.
// ----------------------------------------------------------------------------
module rtk_keyboard (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  rtk_pkg::key_ev_t key_ev_i,
  input  logic [7:0]       column_select_i,
  output logic [7:0]       row_o,
  output logic [4:0]       joy_o
);

  logic [7:0][7:0] matrix_q, matrix_d;
  logic [4:0]      joy_q, joy_d;
  logic [6:0]      map;
  logic [4:0]      joy_bit;
  logic [2:0]      row_idx;
  logic [2:0]      col_idx;

  always_comb begin
    map      = rtk_pkg::key_map(key_ev_i.code);
    row_idx  = map[5:3];
    col_idx  = map[2:0];
    joy_bit  = 5'd0;
    unique case (key_ev_i.code)
      rtk_pkg::KEY_UP:    joy_bit = 5'b00001;
      rtk_pkg::KEY_DOWN:  joy_bit = 5'b00010;
      rtk_pkg::KEY_LEFT:  joy_bit = 5'b00100;
      rtk_pkg::KEY_RIGHT: joy_bit = 5'b01000;
      rtk_pkg::KEY_FIRE:  joy_bit = 5'b10000;
      default:            joy_bit = 5'd0;
    endcase
    matrix_d = matrix_q;
    joy_d    = joy_q;
    if (key_ev_i.en) begin
      joy_d = key_ev_i.down ? (joy_q | joy_bit) : (joy_q & ~joy_bit);
      if (map[6]) begin
        matrix_d[row_idx][col_idx] = ~key_ev_i.down;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      matrix_q <= '1;
      joy_q    <= '0;
    end else begin
      matrix_q <= matrix_d;
      joy_q    <= joy_d;
    end
  end

  always_comb begin
    row_o = 8'hff;
    for (int i = 7; i >= 0; i--) begin
      if (!column_select_i[i]) begin
        row_o = matrix_q[i];
      end
    end
  end

  assign joy_o = joy_q;

endmodule

// ===== rtl/raster_timer_keyboard_io.sv =====
// ----------------------------------------------------------------------------
// raster_timer_keyboard_io
// Raster, timer and keyboard I/O block: bus writes, bus reads, line ticks
// and host key events, one result item per input item.
// ----------------------------------------------------------------------------
// Stages: input register, then result register; state updates as the item
//   leaves the input register. Throughput: one item per cycle while results
//   are taken; m_axis_tready back-pressure reaches s_axis_tready combinationally.
// Reset: rst_ni asynchronous, active low; clears both stages and returns all
//   shadow registers, timer and key matrix to their power-up values.
module raster_timer_keyboard_io #(
  parameter int LINE_CYCLES = 63
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [15:0] address, [23:16] write_data, [32:24] line_number,
  // [40:33] key_code, [41] key_down, [47:42] zero
  input  logic [47:0] s_axis_tdata,
  // [1:0] kind
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] read_data, [8] handled, [9] irq_pulse, [15:10] zero
  output logic [15:0] m_axis_tdata
);

  logic                in_valid_q;
  rtk_pkg::kind_e      in_kind_q;
  logic [15:0]         in_addr_q;
  logic [7:0]          in_wdata_q;
  logic [8:0]          in_line_q;
  logic [7:0]          in_code_q;
  logic                in_down_q;

  logic                out_valid_q;
  logic [7:0]          out_rdata_q, out_rdata_d;
  logic                out_handled_q, out_handled_d;
  logic                out_irq_q, out_irq_d;

  logic [8:0]          line_counter_q, line_counter_d;
  logic [15:0]         timer_count_q, timer_count_d;
  logic                timer_irq_enable_q, timer_irq_enable_d;
  logic                timer_irq_flag_q, timer_irq_flag_d;
  logic [7:0]          raster_control_q, raster_control_d;
  logic [7:0]          raster_compare_q, raster_compare_d;
  logic [7:0]          raster_irq_mask_q, raster_irq_mask_d;
  logic [7:0]          column_select_q, column_select_d;
  logic [15:0]         timer_latch_q, timer_latch_d;
  logic [7:0]          timer_control_q, timer_control_d;

  logic                advance;
  logic                s_accept;
  rtk_pkg::key_ev_t    key_ev;
  logic [7:0]          kb_row;
  logic [4:0]          joy;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  assign key_ev.en   = advance && (in_kind_q == rtk_pkg::KIND_KEY);
  assign key_ev.code = in_code_q;
  assign key_ev.down = in_down_q;

  rtk_keyboard u_keyboard (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .key_ev_i        (key_ev),
    .column_select_i (column_select_q),
    .row_o           (kb_row),
    .joy_o           (joy)
  );

  always_comb begin
    line_counter_d     = line_counter_q;
    timer_count_d      = timer_count_q;
    timer_irq_enable_d = timer_irq_enable_q;
    timer_irq_flag_d   = timer_irq_flag_q;
    raster_control_d   = raster_control_q;
    raster_compare_d   = raster_compare_q;
    raster_irq_mask_d  = raster_irq_mask_q;
    column_select_d    = column_select_q;
    timer_latch_d      = timer_latch_q;
    timer_control_d    = timer_control_q;
    out_rdata_d        = 8'd0;
    out_handled_d      = 1'b0;
    out_irq_d          = 1'b0;

    unique case (in_kind_q)
      rtk_pkg::KIND_WRITE: begin
        unique case (in_addr_q)
          rtk_pkg::ADDR_RASTER_CTRL: raster_control_d = in_wdata_q;
          rtk_pkg::ADDR_RASTER_CMP:  raster_compare_d = in_wdata_q;
          rtk_pkg::ADDR_RASTER_MASK: raster_irq_mask_d = in_wdata_q;
          rtk_pkg::ADDR_PORT_A:      column_select_d = in_wdata_q;
          rtk_pkg::ADDR_TIMER_LO:    timer_latch_d = {timer_latch_q[15:8], in_wdata_q};
          rtk_pkg::ADDR_TIMER_HI:    timer_latch_d = {in_wdata_q, timer_latch_q[7:0]};
          rtk_pkg::ADDR_ICR: begin
            if (in_wdata_q[0]) begin
              timer_irq_enable_d = in_wdata_q[7];
            end
          end
          rtk_pkg::ADDR_TIMER_CTRL: begin
            timer_control_d = in_wdata_q;
            if (in_wdata_q[4]) begin
              timer_count_d = timer_latch_q;
            end
          end
          default: ;
        endcase
      end
      rtk_pkg::KIND_READ: begin
        out_handled_d = 1'b1;
        unique case (in_addr_q)
          rtk_pkg::ADDR_PORT_A:      out_rdata_d = {3'b111, ~joy};
          rtk_pkg::ADDR_PORT_B:      out_rdata_d = kb_row;
          rtk_pkg::ADDR_RASTER_CTRL: out_rdata_d = {line_counter_q[8], raster_control_q[6:0]};
          rtk_pkg::ADDR_RASTER_CMP:  out_rdata_d = line_counter_q[7:0];
          rtk_pkg::ADDR_ICR: begin
            out_rdata_d      = {timer_irq_flag_q, 6'd0, timer_irq_enable_q};
            timer_irq_flag_d = 1'b0;
          end
          default: out_handled_d = 1'b0;
        endcase
      end
      rtk_pkg::KIND_TICK: begin
        line_counter_d = in_line_q;
        if (raster_irq_mask_q[0] && (in_line_q == {raster_control_q[7], raster_compare_q})) begin
          out_irq_d = 1'b1;
        end
        if ((timer_count_q != 16'd0) && timer_control_q[0]) begin
          if (timer_count_q <= 16'(LINE_CYCLES)) begin
            timer_count_d = 16'd0;
            if (timer_irq_enable_q) begin
              timer_irq_flag_d = 1'b1;
              out_irq_d        = 1'b1;
            end
          end else begin
            timer_count_d = timer_count_q - 16'(LINE_CYCLES);
          end
        end
      end
      rtk_pkg::KIND_KEY: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      in_kind_q  <= rtk_pkg::kind_e'(s_axis_tuser);
      in_addr_q  <= s_axis_tdata[15:0];
      in_wdata_q <= s_axis_tdata[23:16];
      in_line_q  <= s_axis_tdata[32:24];
      in_code_q  <= s_axis_tdata[40:33];
      in_down_q  <= s_axis_tdata[41];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_rdata_q   <= out_rdata_d;
      out_handled_q <= out_handled_d;
      out_irq_q     <= out_irq_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_counter_q     <= '0;
      timer_count_q      <= '0;
      timer_irq_enable_q <= 1'b0;
      timer_irq_flag_q   <= 1'b0;
      raster_control_q   <= rtk_pkg::RASTER_CTRL_RESET;
      raster_compare_q   <= '0;
      raster_irq_mask_q  <= '0;
      column_select_q    <= '1;
      timer_latch_q      <= '0;
      timer_control_q    <= '0;
    end else if (advance) begin
      line_counter_q     <= line_counter_d;
      timer_count_q      <= timer_count_d;
      timer_irq_enable_q <= timer_irq_enable_d;
      timer_irq_flag_q   <= timer_irq_flag_d;
      raster_control_q   <= raster_control_d;
      raster_compare_q   <= raster_compare_d;
      raster_irq_mask_q  <= raster_irq_mask_d;
      column_select_q    <= column_select_d;
      timer_latch_q      <= timer_latch_d;
      timer_control_q    <= timer_control_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, out_irq_q, out_handled_q, out_rdata_q};

`ifndef SYNTH
  a_flag_clear_on_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && in_kind_q == rtk_pkg::KIND_READ && in_addr_q == rtk_pkg::ADDR_ICR)
    |=> !timer_irq_flag_q)
    else $error("timer flag not cleared by status read");

  a_timer_no_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(advance && in_kind_q == rtk_pkg::KIND_WRITE && in_addr_q == rtk_pkg::ADDR_TIMER_CTRL)
    |=> timer_count_q <= $past(timer_count_q))
    else $error("timer count rose without a load");

  a_irq_not_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[9]) |-> !m_axis_tdata[8])
    else $error("irq item marked as handled read");

  a_stall_holds_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !advance) |=> (in_valid_q && $stable(in_addr_q)))
    else $error("input stage lost an item while stalled");
`endif

endmodule

// ===== dv/rtk_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtk_checker
// Watches both stream channels of the raster, timer and keyboard I/O block.
// Every accepted input item runs through a local model of the shadow
// registers, timer and key matrix; the predicted result item is queued and
// compared field by field with the next accepted result item.
// ----------------------------------------------------------------------------
module rtk_checker #(
  parameter int LINE_CYCLES = 63
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  // [15:0] address, [23:16] write_data, [32:24] line_number,
  // [40:33] key_code, [41] key_down, [47:42] zero
  input  logic [47:0] s_axis_tdata,
  // [1:0] kind
  input  logic [1:0]  s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] read_data, [8] handled, [9] irq_pulse, [15:10] zero
  input  logic [15:0] m_axis_tdata,
  output int          pending_o,
  output int          fail_o
);

  typedef struct packed {
    logic       irq_pulse;
    logic       handled;
    logic [7:0] read_data;
  } io_result_t;

  logic [8:0]  line_cnt;
  logic [15:0] tmr_count;
  logic        tmr_irq_en;
  logic        tmr_irq_flag;
  logic [7:0]  rast_ctrl;
  logic [7:0]  rast_cmp;
  logic [7:0]  rast_mask;
  logic [7:0]  col_sel;
  logic [15:0] tmr_latch;
  logic [7:0]  tmr_ctrl;
  logic [7:0]  key_rows [8];
  logic [4:0]  joy_bits;

  io_result_t  result_q [$];
  io_result_t  got_res;
  io_result_t  want_res;
  int          fails = 0;

  // bit 6 set: key sits in the matrix, bits 5..0: row * 8 + column
  function automatic logic [6:0] key_slot(input logic [7:0] code);
    case (code)
      8'd27:  return 7'h40 | 7'd63;
      8'd32:  return 7'h40 | 7'd60;
      8'd188: return 7'h40 | 7'd47;
      8'd190: return 7'h40 | 7'd44;
      8'd13:  return 7'h40 | 7'd1;
      8'd8:   return 7'h40 | 7'd0;
      "3":    return 7'h40 | 7'd8;
      "W":    return 7'h40 | 7'd9;
      "A":    return 7'h40 | 7'd10;
      "4":    return 7'h40 | 7'd11;
      "Z":    return 7'h40 | 7'd12;
      "S":    return 7'h40 | 7'd13;
      "E":    return 7'h40 | 7'd14;
      "5":    return 7'h40 | 7'd16;
      "R":    return 7'h40 | 7'd17;
      "D":    return 7'h40 | 7'd18;
      "6":    return 7'h40 | 7'd19;
      "C":    return 7'h40 | 7'd20;
      "F":    return 7'h40 | 7'd21;
      "T":    return 7'h40 | 7'd22;
      "X":    return 7'h40 | 7'd23;
      "7":    return 7'h40 | 7'd24;
      "Y":    return 7'h40 | 7'd25;
      "G":    return 7'h40 | 7'd26;
      "8":    return 7'h40 | 7'd27;
      "B":    return 7'h40 | 7'd28;
      "H":    return 7'h40 | 7'd29;
      "U":    return 7'h40 | 7'd30;
      "V":    return 7'h40 | 7'd31;
      "9":    return 7'h40 | 7'd32;
      "I":    return 7'h40 | 7'd33;
      "J":    return 7'h40 | 7'd34;
      "0":    return 7'h40 | 7'd35;
      "M":    return 7'h40 | 7'd36;
      "K":    return 7'h40 | 7'd37;
      "O":    return 7'h40 | 7'd38;
      "N":    return 7'h40 | 7'd39;
      "P":    return 7'h40 | 7'd41;
      "L":    return 7'h40 | 7'd42;
      "1":    return 7'h40 | 7'd56;
      "2":    return 7'h40 | 7'd59;
      "Q":    return 7'h40 | 7'd62;
      default: return 7'd0;
    endcase
  endfunction

  task automatic reset_io_state();
    line_cnt     = '0;
    tmr_count    = '0;
    tmr_irq_en   = 1'b0;
    tmr_irq_flag = 1'b0;
    rast_ctrl    = rtk_pkg::RASTER_CTRL_RESET;
    rast_cmp     = '0;
    rast_mask    = '0;
    col_sel      = 8'hff;
    tmr_latch    = '0;
    tmr_ctrl     = '0;
    joy_bits     = '0;
    for (int r = 0; r < 8; r++) key_rows[r] = 8'hff;
  endtask

  task automatic predict_io(input logic [1:0] kind, input logic [47:0] payload,
                            output io_result_t res);
    logic [15:0] addr;
    logic [7:0]  wdata;
    logic [8:0]  line;
    logic [7:0]  code;
    logic        down;
    logic [6:0]  slot;
    logic [4:0]  joy_bit;
    addr  = payload[15:0];
    wdata = payload[23:16];
    line  = payload[32:24];
    code  = payload[40:33];
    down  = payload[41];
    res   = '0;
    case (rtk_pkg::kind_e'(kind))
      rtk_pkg::KIND_WRITE: begin
        case (addr)
          rtk_pkg::ADDR_RASTER_CTRL: rast_ctrl = wdata;
          rtk_pkg::ADDR_RASTER_CMP:  rast_cmp  = wdata;
          rtk_pkg::ADDR_RASTER_MASK: rast_mask = wdata;
          rtk_pkg::ADDR_PORT_A:      col_sel   = wdata;
          rtk_pkg::ADDR_TIMER_LO:    tmr_latch[7:0]  = wdata;
          rtk_pkg::ADDR_TIMER_HI:    tmr_latch[15:8] = wdata;
          rtk_pkg::ADDR_ICR: begin
            if (wdata[0]) tmr_irq_en = wdata[7];
          end
          rtk_pkg::ADDR_TIMER_CTRL: begin
            tmr_ctrl = wdata;
            if (wdata[4]) tmr_count = tmr_latch;
          end
          default: ;
        endcase
      end
      rtk_pkg::KIND_READ: begin
        res.handled = 1'b1;
        case (addr)
          rtk_pkg::ADDR_PORT_A: res.read_data = {3'b111, ~joy_bits};
          rtk_pkg::ADDR_PORT_B: begin
            res.read_data = 8'hff;
            for (int c = 7; c >= 0; c--) begin
              if (!col_sel[c]) res.read_data = key_rows[c];
            end
          end
          rtk_pkg::ADDR_RASTER_CTRL: res.read_data = {line_cnt[8], rast_ctrl[6:0]};
          rtk_pkg::ADDR_RASTER_CMP:  res.read_data = line_cnt[7:0];
          rtk_pkg::ADDR_ICR: begin
            res.read_data = {tmr_irq_flag, 6'd0, tmr_irq_en};
            tmr_irq_flag  = 1'b0;
          end
          default: res.handled = 1'b0;
        endcase
      end
      rtk_pkg::KIND_TICK: begin
        line_cnt = line;
        if (rast_mask[0] && line == {rast_ctrl[7], rast_cmp}) res.irq_pulse = 1'b1;
        if (tmr_count != 16'd0 && tmr_ctrl[0]) begin
          if (tmr_count <= 16'(LINE_CYCLES)) begin
            tmr_count = '0;
            if (tmr_irq_en) begin
              tmr_irq_flag  = 1'b1;
              res.irq_pulse = 1'b1;
            end
          end else begin
            tmr_count = tmr_count - 16'(LINE_CYCLES);
          end
        end
      end
      default: begin
        case (code)
          rtk_pkg::KEY_UP:    joy_bit = 5'h01;
          rtk_pkg::KEY_DOWN:  joy_bit = 5'h02;
          rtk_pkg::KEY_LEFT:  joy_bit = 5'h04;
          rtk_pkg::KEY_RIGHT: joy_bit = 5'h08;
          rtk_pkg::KEY_FIRE:  joy_bit = 5'h10;
          default:            joy_bit = 5'h00;
        endcase
        if (down) joy_bits = joy_bits | joy_bit;
        else joy_bits = joy_bits & ~joy_bit;
        slot = key_slot(code);
        if (slot[6]) key_rows[slot[5:3]][slot[2:0]] = ~down;
      end
    endcase
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reset_io_state();
      result_q.delete();
      pending_o <= 0;
      fail_o    <= fails;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got_res = io_result_t'(m_axis_tdata[9:0]);
        if (result_q.size() == 0) begin
          $error("result item with nothing expected: tdata %0h", m_axis_tdata);
          fails++;
        end else begin
          want_res = result_q.pop_front();
          check_field("read_data", want_res.read_data, got_res.read_data);
          check_field("handled", 8'(want_res.handled), 8'(got_res.handled));
          check_field("irq_pulse", 8'(want_res.irq_pulse), 8'(got_res.irq_pulse));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        predict_io(s_axis_tuser, s_axis_tdata, want_res);
        result_q.push_back(want_res);
      end
      pending_o <= result_q.size();
      fail_o    <= fails;
    end
  end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the raster, timer and keyboard I/O block: a
// directed pass over register reads, raster match, timer expiry and key
// events, then random bus traffic, line ticks and key events under several
// idle and stall patterns. Checking is done by rtk_checker.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int LINE_CYCLES     = 63;
  localparam int ITEMS_PER_PHASE = 500;
  localparam int DRAIN_CYCLES    = 8;
  localparam int WATCHDOG_LIMIT  = 5000;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata  = '0;
  logic [1:0]  s_axis_tuser  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;

  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  int          pending_cnt;
  int          fail_cnt;
  int          quiet_cycles   = 0;
  logic [8:0]  raster_target  = '0;

  raster_timer_keyboard_io #(
    .LINE_CYCLES(LINE_CYCLES)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  rtk_checker #(
    .LINE_CYCLES(LINE_CYCLES)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .pending_o    (pending_cnt),
    .fail_o       (fail_cnt)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  task automatic send_item(input rtk_pkg::kind_e kind, input logic [15:0] addr,
                           input logic [7:0] data, input logic [8:0] line,
                           input logic [7:0] code, input logic down);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    if (kind == rtk_pkg::KIND_WRITE && addr == rtk_pkg::ADDR_RASTER_CTRL) begin
      raster_target[8] = data[7];
    end
    if (kind == rtk_pkg::KIND_WRITE && addr == rtk_pkg::ADDR_RASTER_CMP) begin
      raster_target[7:0] = data;
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'd0, down, code, line, data, addr};
    s_axis_tuser  <= kind;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic send_random_item();
    rtk_pkg::kind_e kind;
    logic [15:0]    addr;
    logic [7:0]     data;
    logic [8:0]     line;
    logic [7:0]     code;
    logic           down;
    logic [6:0]     slot;
    int             roll;
    addr = 16'($urandom);
    data = 8'($urandom);
    line = 9'($urandom_range(511));
    code = 8'($urandom_range(255));
    down = 1'($urandom_range(1));
    roll = $urandom_range(99);
    if (roll < 30) begin
      kind = rtk_pkg::KIND_WRITE;
      case ($urandom_range(9))
        0: addr = rtk_pkg::ADDR_RASTER_CTRL;
        1: addr = rtk_pkg::ADDR_RASTER_CMP;
        2: addr = rtk_pkg::ADDR_RASTER_MASK;
        3: begin
          addr = rtk_pkg::ADDR_PORT_A;
          if ($urandom_range(1)) data = ~(8'd1 << $urandom_range(7));
        end
        4: addr = rtk_pkg::ADDR_TIMER_LO;
        5: begin
          addr = rtk_pkg::ADDR_TIMER_HI;
          if ($urandom_range(4) != 0) data = 8'd0;
        end
        6: addr = rtk_pkg::ADDR_ICR;
        7: addr = rtk_pkg::ADDR_TIMER_CTRL;
        8: addr = rtk_pkg::ADDR_PORT_B;
        default: ;
      endcase
    end else if (roll < 60) begin
      kind = rtk_pkg::KIND_READ;
      case ($urandom_range(7))
        0: addr = rtk_pkg::ADDR_RASTER_CTRL;
        1: addr = rtk_pkg::ADDR_RASTER_CMP;
        2: addr = rtk_pkg::ADDR_PORT_A;
        3, 4: addr = rtk_pkg::ADDR_PORT_B;
        5, 6: addr = rtk_pkg::ADDR_ICR;
        default: ;
      endcase
    end else if (roll < 85) begin
      kind = rtk_pkg::KIND_TICK;
      if ($urandom_range(9) < 4) line = raster_target;
    end else begin
      kind = rtk_pkg::KIND_KEY;
      roll = $urandom_range(9);
      if (roll < 6) begin
        do begin
          code = 8'($urandom_range(255));
          slot = rtk_pkg::key_map(code);
        end while (!slot[6]);
      end else if (roll < 8) begin
        case ($urandom_range(4))
          0: code = rtk_pkg::KEY_UP;
          1: code = rtk_pkg::KEY_DOWN;
          2: code = rtk_pkg::KEY_LEFT;
          3: code = rtk_pkg::KEY_RIGHT;
          default: code = rtk_pkg::KEY_FIRE;
        endcase
      end
    end
    send_item(kind, addr, data, line, code, down);
  endtask

  task automatic wait_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_cnt != 0);
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_item(rtk_pkg::KIND_READ,  rtk_pkg::ADDR_RASTER_CTRL, 8'h00, 9'h000, 8'h00, 1'b0);
    send_item(rtk_pkg::KIND_READ,  rtk_pkg::ADDR_PORT_A,      8'h00, 9'h000, 8'h00, 1'b0);
    send_item(rtk_pkg::KIND_READ,  rtk_pkg::ADDR_PORT_B,      8'h00, 9'h000, 8'h00, 1'b0);
    send_item(rtk_pkg::KIND_READ,  rtk_pkg::ADDR_ICR,         8'h00, 9'h000, 8'h00, 1'b0);
    send_item(rtk_pkg::KIND_READ,  16'h0000,                  8'hff, 9'h1ff, 8'hff, 1'b1);
    send_item(rtk_pkg::KIND_READ,  16'hffff,                  8'h00, 9'h000, 8'h00, 1'b0);
    send_item(rtk_pkg::KIND_WRITE, rtk_pkg::ADDR_RASTER_MASK, 8'h01, 9'h000, 8'h00, 1'b0);
    send_item(rtk_pkg::KIND_WRITE, rtk_pkg::ADDR_RASTER_CMP,  8'hff, 9'h000, 8'h00, 1'b0);
    send_item(rtk_pkg::KIND_WRITE, rtk_pkg::ADDR_RASTER_CTRL, 8'h80, 9'h000, 8'h00, 1'b0);
    send_item(rtk_pkg::KIND_TICK,  16'h0000,                  8'h00, 9'h1ff, 8'h00, 1'b0);
    send_item(rtk_pkg::KIND_READ,  rtk_pkg::ADDR_RASTER_CTRL, 8'h00, 9'h000, 8'h00, 1'b0);
    send_item(rtk_pkg::KIND_TICK,  16'h0000,                  8'h00, 9'h000, 8'h00, 1'b0);
    send_item(rtk_pkg::KIND_WRITE, rtk_pkg::ADDR_TIMER_LO,    8'h40, 9'h000, 8'h00, 1'b0);
    send_item(rtk_pkg::KIND_WRITE, rtk_pkg::ADDR_TIMER_HI,    8'h00, 9'h000, 8'h00, 1'b0);
    send_item(rtk_pkg::KIND_WRITE, rtk_pkg::ADDR_ICR,         8'h81, 9'h000, 8'h00, 1'b0);
    send_item(rtk_pkg::KIND_WRITE, rtk_pkg::ADDR_TIMER_CTRL,  8'h11, 9'h000, 8'h00, 1'b0);
    send_item(rtk_pkg::KIND_TICK,  16'h0000,                  8'h00, 9'd100, 8'h00, 1'b0);
    send_item(rtk_pkg::KIND_TICK,  16'h0000,                  8'h00, 9'd101, 8'h00, 1'b0);
    send_item(rtk_pkg::KIND_READ,  rtk_pkg::ADDR_ICR,         8'h00, 9'h000, 8'h00, 1'b0);
    send_item(rtk_pkg::KIND_READ,  rtk_pkg::ADDR_ICR,         8'h00, 9'h000, 8'h00, 1'b0);
    send_item(rtk_pkg::KIND_WRITE, rtk_pkg::ADDR_ICR,         8'h80, 9'h000, 8'h00, 1'b0);
    send_item(rtk_pkg::KIND_WRITE, rtk_pkg::ADDR_ICR,         8'h01, 9'h000, 8'h00, 1'b0);
    send_item(rtk_pkg::KIND_KEY,   16'h0000,                  8'h00, 9'h000, "A",   1'b1);
    send_item(rtk_pkg::KIND_WRITE, rtk_pkg::ADDR_PORT_A,      8'hfd, 9'h000, 8'h00, 1'b0);
    send_item(rtk_pkg::KIND_READ,  rtk_pkg::ADDR_PORT_B,      8'h00, 9'h000, 8'h00, 1'b0);
    send_item(rtk_pkg::KIND_KEY,   16'h0000,                  8'h00, 9'h000,
              rtk_pkg::KEY_FIRE, 1'b1);
    send_item(rtk_pkg::KIND_KEY,   16'h0000,                  8'h00, 9'h000, 8'hff, 1'b1);
    send_item(rtk_pkg::KIND_READ,  rtk_pkg::ADDR_PORT_A,      8'h00, 9'h000, 8'h00, 1'b0);
    send_item(rtk_pkg::KIND_WRITE, 16'hffff,                  8'hff, 9'h000, 8'h00, 1'b0);
    wait_results();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
        default: begin send_idle_pct = 28; recv_stall_pct = 28; end
      endcase
      repeat (ITEMS_PER_PHASE) send_random_item();
      wait_results();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/rtk_pkg.sv
rtl/rtk_keyboard.sv
rtl/raster_timer_keyboard_io.sv
dv/rtk_checker.sv
dv/tb_top.sv
